@@ rtl/bba_pkg.sv @@
// ----------------------------------------------------------------------------
// bba_pkg
// Shared types, constants and helpers for the buddy block allocator.
// ----------------------------------------------------------------------------
package bba_pkg;

    localparam int TREE_LEVELS = 10;
    localparam int NODE_COUNT  = (2 ** (TREE_LEVELS + 1)) - 1;
    localparam int IDX_W       = TREE_LEVELS + 1;
    localparam int LVL_W       = $clog2(TREE_LEVELS + 2);
    localparam int POS_W       = TREE_LEVELS;
    localparam int NOW_W       = 48;
    localparam int AGE_W       = 16;
    localparam int ORD_W       = 6;
    localparam int OFF_W       = 40;
    localparam int SIZE_W      = 41;
    localparam int NAME_W      = 8;
    localparam int CIDX_W      = 8;

    localparam logic [ORD_W-1:0] MAX_ORDER   = 6'd40;
    localparam logic [ORD_W-1:0] RST_TOP_ORD = 6'd10;
    localparam logic [ORD_W-1:0] RST_MIN_ORD = 6'd0;

    localparam logic REQ_ALLOC = 1'b0;
    localparam logic REQ_FREE  = 1'b1;

    localparam logic [CIDX_W-1:0] REG_TOP_ORDER = 8'd0;
    localparam logic [CIDX_W-1:0] REG_MIN_ORDER = 8'd1;

    typedef enum logic [1:0] {
        KIND_ABSENT = 2'd0,
        KIND_FREE   = 2'd1,
        KIND_SPLIT  = 2'd2,
        KIND_USED   = 2'd3
    } kind_t;

    localparam logic [1:0] ST_ALLOCATED = 2'd0;
    localparam logic [1:0] ST_FREED     = 2'd1;
    localparam logic [1:0] ST_NO_FIT    = 2'd2;
    localparam logic [1:0] ST_NOT_FOUND = 2'd3;

    typedef struct packed {
        logic              req_type;
        logic [NAME_W-1:0] block_name;
        logic [SIZE_W-1:0] request_size;
    } bba_in_t;

    typedef struct packed {
        logic [1:0]       status;
        logic [OFF_W-1:0] block_offset;
        logic [ORD_W-1:0] block_order;
    } bba_out_t;

    typedef struct packed {
        logic              kind_we;
        logic              owner_we;
        logic              stamp_we;
        logic [IDX_W-1:0]  addr;
        kind_t             kind;
        logic [NAME_W-1:0] owner;
        logic [NOW_W-1:0]  stamp;
    } bba_wr_t;

    function automatic logic fits(input logic [SIZE_W-1:0] size, input logic [ORD_W-1:0] ord);
        return size <= (SIZE_W'(1) << ord);
    endfunction

endpackage

@@ rtl/buddy_block_allocator.sv @@
// ----------------------------------------------------------------------------
// buddy_block_allocator
// Binary buddy allocator: allocate by size, free by owner name, one result
// per request.
// ----------------------------------------------------------------------------
// A request reads the node store one node per cycle through its single read
// port, level by level, scanning up to 2047 nodes for a full tree (fewer
// when the region order or the request size ends the scan early), then
// runs its split or merge steps. The block takes no new request until the
// result is placed in the output register. After reset and after each
// top_order write a clearing pass over all 2047 nodes runs before the first
// request is taken.
module buddy_block_allocator (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       in_valid,
    output logic                       in_stall,
    input  bba_pkg::bba_in_t           in_data,
    output logic                       out_valid,
    input  logic                       out_stall,
    output bba_pkg::bba_out_t          out_data,
    input  logic                       cfg_valid,
    output logic                       cfg_ready,
    input  logic [bba_pkg::CIDX_W-1:0] cfg_index,
    input  logic [bba_pkg::ORD_W-1:0]  cfg_data
);
    import bba_pkg::*;

    logic [ORD_W-1:0]  top_reg, top_next;
    logic [ORD_W-1:0]  min_reg, min_next;
    logic [ORD_W-1:0]  cfg_sat;
    logic              cfg_xfer;
    logic              clear_start;
    bba_wr_t           wr;
    logic [IDX_W-1:0]  rd_addr;
    kind_t             rd_kind;
    logic [NAME_W-1:0] rd_owner;
    logic [NOW_W-1:0]  rd_stamp;

    assign cfg_ready   = 1'b1;
    assign cfg_xfer    = cfg_valid && cfg_ready;
    assign cfg_sat     = (cfg_data > MAX_ORDER) ? MAX_ORDER : cfg_data;
    assign clear_start = cfg_xfer && (cfg_index == REG_TOP_ORDER);

    always_comb
    begin
        top_next = top_reg;
        min_next = min_reg;
        if (cfg_xfer)
        begin
            case (cfg_index)
                REG_TOP_ORDER: top_next = cfg_sat;
                REG_MIN_ORDER: min_next = cfg_sat;
                default:       top_next = top_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            top_reg <= RST_TOP_ORD;
            min_reg <= RST_MIN_ORD;
        end
        else
        begin
            top_reg <= top_next;
            min_reg <= min_next;
        end
    end

    bba_store u_store (
        .clk      (clk),
        .wr       (wr),
        .rd_addr  (rd_addr),
        .rd_kind  (rd_kind),
        .rd_owner (rd_owner),
        .rd_stamp (rd_stamp)
    );

    bba_seq u_seq (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .in_data     (in_data),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .out_data    (out_data),
        .clear_start (clear_start),
        .top_order   (top_reg),
        .min_order   (min_reg),
        .wr          (wr),
        .rd_addr     (rd_addr),
        .rd_kind     (rd_kind),
        .rd_owner    (rd_owner),
        .rd_stamp    (rd_stamp)
    );

endmodule

@@ rtl/bba_store.sv @@
// ----------------------------------------------------------------------------
// bba_store
// Node store: kind, owner and free stamp per tree node, one write and one
// registered read per cycle.
// ----------------------------------------------------------------------------
module bba_store (
    input  logic                       clk,
    input  bba_pkg::bba_wr_t           wr,
    input  logic [bba_pkg::IDX_W-1:0]  rd_addr,
    output bba_pkg::kind_t             rd_kind,
    output logic [bba_pkg::NAME_W-1:0] rd_owner,
    output logic [bba_pkg::NOW_W-1:0]  rd_stamp
);
    import bba_pkg::*;

    kind_t             kind_mem  [NODE_COUNT];
    logic [NAME_W-1:0] owner_mem [NODE_COUNT];
    logic [NOW_W-1:0]  stamp_mem [NODE_COUNT];

    kind_t             kind_reg;
    logic [NAME_W-1:0] owner_reg;
    logic [NOW_W-1:0]  stamp_reg;

    always_ff @(posedge clk)
    begin
        if (wr.kind_we)
        begin
            kind_mem[wr.addr] <= wr.kind;
        end
        if (wr.owner_we)
        begin
            owner_mem[wr.addr] <= wr.owner;
        end
        if (wr.stamp_we)
        begin
            stamp_mem[wr.addr] <= wr.stamp;
        end
        kind_reg  <= kind_mem[rd_addr];
        owner_reg <= owner_mem[rd_addr];
        stamp_reg <= stamp_mem[rd_addr];
    end

    assign rd_kind  = kind_reg;
    assign rd_owner = owner_reg;
    assign rd_stamp = stamp_reg;

endmodule

@@ rtl/bba_seq.sv @@
// ----------------------------------------------------------------------------
// bba_seq
// Request sequencer: clearing pass, node scan with a shared compare unit,
// split and merge steps, result register.
// ----------------------------------------------------------------------------
module bba_seq (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       in_valid,
    output logic                       in_stall,
    input  bba_pkg::bba_in_t           in_data,
    output logic                       out_valid,
    input  logic                       out_stall,
    output bba_pkg::bba_out_t          out_data,
    input  logic                       clear_start,
    input  logic [bba_pkg::ORD_W-1:0]  top_order,
    input  logic [bba_pkg::ORD_W-1:0]  min_order,
    output bba_pkg::bba_wr_t           wr,
    output logic [bba_pkg::IDX_W-1:0]  rd_addr,
    input  bba_pkg::kind_t             rd_kind,
    input  logic [bba_pkg::NAME_W-1:0] rd_owner,
    input  logic [bba_pkg::NOW_W-1:0]  rd_stamp
);
    import bba_pkg::*;

    typedef enum logic [17:0] {
        S_CLEAR     = 18'b000000000000000001,
        S_IDLE      = 18'b000000000000000010,
        S_SCAN      = 18'b000000000000000100,
        S_RESOLVE   = 18'b000000000000001000,
        S_SPLIT_CHK = 18'b000000000000010000,
        S_SPLIT_W0  = 18'b000000000000100000,
        S_SPLIT_W1  = 18'b000000000001000000,
        S_SPLIT_W2  = 18'b000000000010000000,
        S_ALLOC_FIN = 18'b000000000100000000,
        S_FREE_W    = 18'b000000001000000000,
        S_MERGE_CHK = 18'b000000010000000000,
        S_MERGE_RD  = 18'b000000100000000000,
        S_MERGE_EV  = 18'b000001000000000000,
        S_MERGE_W0  = 18'b000010000000000000,
        S_MERGE_W1  = 18'b000100000000000000,
        S_MERGE_W2  = 18'b001000000000000000,
        S_DONE      = 18'b010000000000000000,
        S_SPARE     = 18'b100000000000000000
    } state_t;

    state_t            state_reg, state_next;
    logic [IDX_W-1:0]  clr_reg, clr_next;
    bba_in_t           req_reg, req_next;
    logic [LVL_W-1:0]  d_reg, d_next;
    logic [POS_W-1:0]  p_reg, p_next;
    logic              cmp_valid_reg, cmp_valid_next;
    logic [LVL_W-1:0]  cmp_d_reg, cmp_d_next;
    logic [POS_W-1:0]  cmp_p_reg, cmp_p_next;
    logic [IDX_W-1:0]  cmp_idx_reg, cmp_idx_next;
    logic              found_reg, found_next;
    logic [IDX_W-1:0]  best_reg, best_next;
    logic [LVL_W-1:0]  best_d_reg, best_d_next;
    logic [AGE_W-1:0]  best_age_reg, best_age_next;
    logic [OFF_W-1:0]  best_off_reg, best_off_next;
    logic              left_free_reg, left_free_next;
    logic [NOW_W-1:0]  now_reg, now_next;
    bba_out_t          res_reg, res_next;
    logic              out_valid_reg, out_valid_next;
    bba_out_t          out_data_reg, out_data_next;

    logic [ORD_W-1:0]  limit;
    logic [ORD_W-1:0]  ord_scan;
    logic [IDX_W-1:0]  base;
    logic              scan_stop;
    logic [ORD_W-1:0]  ord_cmp;
    logic [NOW_W-1:0]  age_diff;
    logic [AGE_W-1:0]  age;
    logic [OFF_W-1:0]  off;
    logic              hit;
    logic [ORD_W-1:0]  ord_best;
    logic              split_ok;
    logic [IDX_W-1:0]  child_l;
    logic [IDX_W-1:0]  sib_l;
    logic [IDX_W-1:0]  parent;

    always_comb
    begin
        limit     = (top_order < ORD_W'(TREE_LEVELS)) ? top_order : ORD_W'(TREE_LEVELS);
        ord_scan  = top_order - ORD_W'(d_reg);
        base      = (IDX_W'(1) << d_reg) - IDX_W'(1);
        scan_stop = (ORD_W'(d_reg) > limit) ||
                    ((req_reg.req_type == REQ_ALLOC) && !fits(req_reg.request_size, ord_scan));

        // shared compare unit
        ord_cmp  = top_order - ORD_W'(cmp_d_reg);
        age_diff = now_reg - rd_stamp;
        age      = (|age_diff[NOW_W-1:AGE_W]) ? {AGE_W{1'b1}} : age_diff[AGE_W-1:0];
        off      = OFF_W'(cmp_p_reg) << ord_cmp;
        if (req_reg.req_type == REQ_ALLOC)
        begin
            hit = (rd_kind == KIND_FREE) &&
                  (!found_reg || (cmp_d_reg > best_d_reg) || (age < best_age_reg));
        end
        else
        begin
            hit = (rd_kind == KIND_USED) && (rd_owner == req_reg.block_name) &&
                  (!found_reg || (off > best_off_reg));
        end

        ord_best = top_order - ORD_W'(best_d_reg);
        split_ok = (ord_best >= ORD_W'(1)) && (best_d_reg < LVL_W'(TREE_LEVELS)) &&
                   ((ord_best - ORD_W'(1)) >= min_order) &&
                   fits(req_reg.request_size, ord_best - ORD_W'(1));
        child_l  = {best_reg[IDX_W-2:0], 1'b1};
        sib_l    = best_reg[0] ? best_reg : (best_reg - IDX_W'(1));
        parent   = (best_reg - IDX_W'(1)) >> 1;
    end

    always_comb
    begin
        state_next     = state_reg;
        clr_next       = clr_reg;
        req_next       = req_reg;
        d_next         = d_reg;
        p_next         = p_reg;
        cmp_valid_next = 1'b0;
        cmp_d_next     = cmp_d_reg;
        cmp_p_next     = cmp_p_reg;
        cmp_idx_next   = cmp_idx_reg;
        found_next     = found_reg;
        best_next      = best_reg;
        best_d_next    = best_d_reg;
        best_age_next  = best_age_reg;
        best_off_next  = best_off_reg;
        left_free_next = left_free_reg;
        now_next       = now_reg;
        res_next       = res_reg;
        out_valid_next = out_valid_reg;
        out_data_next  = out_data_reg;
        rd_addr        = base + IDX_W'(p_reg);
        wr             = '0;
        wr.stamp       = now_reg;
        wr.owner       = req_reg.block_name;

        if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end

        if (cmp_valid_reg && hit)
        begin
            found_next    = 1'b1;
            best_next     = cmp_idx_reg;
            best_d_next   = cmp_d_reg;
            best_age_next = age;
            best_off_next = off;
        end

        case (state_reg)
            S_CLEAR:
            begin
                wr.kind_we  = 1'b1;
                wr.addr     = clr_reg;
                wr.kind     = (clr_reg == '0) ? KIND_FREE : KIND_ABSENT;
                wr.stamp_we = (clr_reg == '0);
                clr_next    = clr_reg + IDX_W'(1);
                if (clr_reg == IDX_W'(NODE_COUNT - 1))
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (in_valid)
                begin
                    req_next   = in_data;
                    d_next     = '0;
                    p_next     = '0;
                    found_next = 1'b0;
                    state_next = S_SCAN;
                end
            end
            S_SCAN:
            begin
                if (scan_stop)
                begin
                    state_next = S_RESOLVE;
                end
                else
                begin
                    cmp_valid_next = 1'b1;
                    cmp_d_next     = d_reg;
                    cmp_p_next     = p_reg;
                    cmp_idx_next   = base + IDX_W'(p_reg);
                    if (IDX_W'(p_reg) == base)
                    begin
                        p_next = '0;
                        d_next = d_reg + LVL_W'(1);
                    end
                    else
                    begin
                        p_next = p_reg + POS_W'(1);
                    end
                end
            end
            S_RESOLVE:
            begin
                if (!found_reg)
                begin
                    res_next.status       = (req_reg.req_type == REQ_ALLOC) ?
                                            ST_NO_FIT : ST_NOT_FOUND;
                    res_next.block_offset = '0;
                    res_next.block_order  = '0;
                    state_next            = S_DONE;
                end
                else if (req_reg.req_type == REQ_ALLOC)
                begin
                    state_next = S_SPLIT_CHK;
                end
                else
                begin
                    state_next = S_FREE_W;
                end
            end
            S_SPLIT_CHK:
            begin
                state_next = split_ok ? S_SPLIT_W0 : S_ALLOC_FIN;
            end
            S_SPLIT_W0:
            begin
                wr.kind_we = 1'b1;
                wr.addr    = best_reg;
                wr.kind    = KIND_SPLIT;
                state_next = S_SPLIT_W1;
            end
            S_SPLIT_W1:
            begin
                wr.kind_we  = 1'b1;
                wr.stamp_we = 1'b1;
                wr.addr     = child_l;
                wr.kind     = KIND_FREE;
                state_next  = S_SPLIT_W2;
            end
            S_SPLIT_W2:
            begin
                wr.kind_we  = 1'b1;
                wr.stamp_we = 1'b1;
                wr.addr     = child_l + IDX_W'(1);
                wr.kind     = KIND_FREE;
                best_next   = child_l;
                best_d_next = best_d_reg + LVL_W'(1);
                state_next  = S_SPLIT_CHK;
            end
            S_ALLOC_FIN:
            begin
                wr.kind_we            = 1'b1;
                wr.owner_we           = 1'b1;
                wr.addr               = best_reg;
                wr.kind               = KIND_USED;
                res_next.status       = ST_ALLOCATED;
                res_next.block_offset = best_off_reg;
                res_next.block_order  = ord_best;
                state_next            = S_DONE;
            end
            S_FREE_W:
            begin
                wr.kind_we            = 1'b1;
                wr.stamp_we           = 1'b1;
                wr.addr               = best_reg;
                wr.kind               = KIND_FREE;
                res_next.status       = ST_FREED;
                res_next.block_offset = best_off_reg;
                res_next.block_order  = ord_best;
                state_next            = S_MERGE_CHK;
            end
            S_MERGE_CHK:
            begin
                rd_addr    = sib_l;
                state_next = (best_reg == '0) ? S_DONE : S_MERGE_RD;
            end
            S_MERGE_RD:
            begin
                rd_addr        = sib_l + IDX_W'(1);
                left_free_next = (rd_kind == KIND_FREE);
                state_next     = S_MERGE_EV;
            end
            S_MERGE_EV:
            begin
                state_next = (left_free_reg && (rd_kind == KIND_FREE)) ? S_MERGE_W0 : S_DONE;
            end
            S_MERGE_W0:
            begin
                wr.kind_we = 1'b1;
                wr.addr    = sib_l;
                wr.kind    = KIND_ABSENT;
                state_next = S_MERGE_W1;
            end
            S_MERGE_W1:
            begin
                wr.kind_we = 1'b1;
                wr.addr    = sib_l + IDX_W'(1);
                wr.kind    = KIND_ABSENT;
                state_next = S_MERGE_W2;
            end
            S_MERGE_W2:
            begin
                wr.kind_we  = 1'b1;
                wr.stamp_we = 1'b1;
                wr.addr     = parent;
                wr.kind     = KIND_FREE;
                best_next   = parent;
                state_next  = S_MERGE_CHK;
            end
            S_DONE:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    out_valid_next = 1'b1;
                    out_data_next  = res_reg;
                    now_next       = now_reg + NOW_W'(1);
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        if (clear_start)
        begin
            clr_next   = '0;
            state_next = S_CLEAR;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            clr_reg       <= '0;
            cmp_valid_reg <= 1'b0;
            found_reg     <= 1'b0;
            now_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            clr_reg       <= clr_next;
            cmp_valid_reg <= cmp_valid_next;
            found_reg     <= found_next;
            now_reg       <= now_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        req_reg       <= req_next;
        d_reg         <= d_next;
        p_reg         <= p_next;
        cmp_d_reg     <= cmp_d_next;
        cmp_p_reg     <= cmp_p_next;
        cmp_idx_reg   <= cmp_idx_next;
        best_reg      <= best_next;
        best_d_reg    <= best_d_next;
        best_age_reg  <= best_age_next;
        best_off_reg  <= best_off_next;
        left_free_reg <= left_free_next;
        res_reg       <= res_next;
        out_data_reg  <= out_data_next;
    end

    assign in_stall  = (state_reg != S_IDLE);
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

endmodule

@@ rtl/bba_check.sv @@
// ----------------------------------------------------------------------------
// bba_check
// Port-level checks for the buddy block allocator.
// ----------------------------------------------------------------------------
module bba_check (
    input logic                       clk,
    input logic                       rst_n,
    input logic                       in_valid,
    input logic                       in_stall,
    input bba_pkg::bba_in_t           in_data,
    input logic                       out_valid,
    input logic                       out_stall,
    input bba_pkg::bba_out_t          out_data,
    input logic                       cfg_valid,
    input logic                       cfg_ready,
    input logic [bba_pkg::CIDX_W-1:0] cfg_index,
    input logic [bba_pkg::ORD_W-1:0]  cfg_data
);
    import bba_pkg::*;

    // a held result stays put
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(out_data))
        else $error("result changed while stalled");

    // one request at a time
    a_in_busy: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=> in_stall)
        else $error("request taken while busy");

    // failures report no block
    a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && ((out_data.status == ST_NO_FIT) || (out_data.status == ST_NOT_FOUND))
        |-> (out_data.block_offset == '0) && (out_data.block_order == '0))
        else $error("failure with nonzero block");

    // block order never exceeds the maximum order
    a_order_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> out_data.block_order <= MAX_ORDER)
        else $error("block order out of range");

endmodule

bind buddy_block_allocator bba_check u_check (.*);

@@ tb/buddy_block_allocator_tb.sv @@
// ----------------------------------------------------------------------------
// buddy_block_allocator_tb
// Self-checking bench for the buddy block allocator. Requests are driven with
// random gaps, results are taken with random stalls, and every result is
// compared field by field against an in-bench model of the block tree that
// is updated as each request is accepted. Runs directed corner cases first,
// then random allocate/free traffic under several region and block orders.
// ----------------------------------------------------------------------------
module buddy_block_allocator_tb;
    timeunit 1ns;
    timeprecision 1ps;
    import bba_pkg::*;

    localparam longint CYCLE_LIMIT = 40_000_000;

    logic              clk;
    logic              rst_n;
    logic              in_valid;
    logic              in_stall;
    bba_in_t           in_data;
    logic              out_valid;
    logic              out_stall;
    bba_out_t          out_data;
    logic              cfg_valid;
    logic              cfg_ready;
    logic [CIDX_W-1:0] cfg_index;
    logic [ORD_W-1:0]  cfg_data;

    kind_t             tree_kind [NODE_COUNT];
    logic [NAME_W-1:0] tree_owner [NODE_COUNT];
    logic [AGE_W-1:0]  tree_age [NODE_COUNT];
    int unsigned       region_ord;
    int unsigned       floor_ord;

    bba_out_t          expect_mem [1024];
    int                exp_wr = 0;
    int                exp_rd = 0;
    int                n_errors;
    longint            cycles;
    int                stall_pct;
    int                gap_pct;
    logic [NAME_W-1:0] name_pool [6];

    buddy_block_allocator u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    function automatic void clear_tree();
        for (int i = 0; i < NODE_COUNT; i++)
        begin
            tree_kind[i]  = KIND_ABSENT;
            tree_owner[i] = '0;
            tree_age[i]   = '0;
        end
        tree_kind[0] = KIND_FREE;
    endfunction

    function automatic bba_out_t buddy_predict(input bba_in_t req);
        bba_out_t         res;
        bit               found;
        int unsigned      best;
        int unsigned      best_d;
        int unsigned      ord;
        int unsigned      idx;
        int unsigned      par;
        int unsigned      lft;
        longint unsigned  sz;
        longint unsigned  off;
        longint unsigned  best_off;
        res      = '0;
        found    = 1'b0;
        best     = 0;
        best_d   = 0;
        best_off = 0;
        sz       = longint'(req.request_size);
        if (req.req_type == REQ_ALLOC)
        begin
            for (int unsigned d = 0; d <= TREE_LEVELS && d <= region_ord; d++)
            begin
                ord = region_ord - d;
                if (sz > (64'd1 << ord))
                    break;
                for (int unsigned p = 0; p < (1 << d); p++)
                begin
                    idx = (1 << d) - 1 + p;
                    if (tree_kind[idx] == KIND_FREE &&
                        (!found || d > best_d || tree_age[idx] < tree_age[best]))
                    begin
                        best   = idx;
                        best_d = d;
                        found  = 1'b1;
                    end
                end
            end
            if (!found)
                res.status = ST_NO_FIT;
            else
            begin
                ord = region_ord - best_d;
                while (ord >= 1 && best_d + 1 <= TREE_LEVELS && ord - 1 >= floor_ord &&
                       sz <= (64'd1 << (ord - 1)))
                begin
                    lft = 2 * best + 1;
                    tree_kind[best]    = KIND_SPLIT;
                    tree_kind[lft]     = KIND_FREE;
                    tree_kind[lft + 1] = KIND_FREE;
                    tree_age[lft]      = '0;
                    tree_age[lft + 1]  = '0;
                    best = lft;
                    best_d++;
                    ord = region_ord - best_d;
                end
                tree_kind[best]  = KIND_USED;
                tree_owner[best] = req.block_name;
                res.status       = ST_ALLOCATED;
                res.block_offset = OFF_W'(longint'(best - ((1 << best_d) - 1)) << ord);
                res.block_order  = ORD_W'(ord);
            end
        end
        else
        begin
            for (int unsigned d = 0; d <= TREE_LEVELS && d <= region_ord; d++)
            begin
                ord = region_ord - d;
                for (int unsigned p = 0; p < (1 << d); p++)
                begin
                    idx = (1 << d) - 1 + p;
                    off = longint'(p) << ord;
                    if (tree_kind[idx] == KIND_USED && tree_owner[idx] == req.block_name &&
                        (!found || off > best_off))
                    begin
                        best     = idx;
                        best_d   = d;
                        best_off = off;
                        found    = 1'b1;
                    end
                end
            end
            if (!found)
                res.status = ST_NOT_FOUND;
            else
            begin
                res.status       = ST_FREED;
                res.block_offset = OFF_W'(best_off);
                res.block_order  = ORD_W'(region_ord - best_d);
                tree_kind[best]  = KIND_FREE;
                tree_age[best]   = '0;
                while (best != 0)
                begin
                    par = (best - 1) / 2;
                    lft = 2 * par + 1;
                    if (tree_kind[lft] != KIND_FREE || tree_kind[lft + 1] != KIND_FREE)
                        break;
                    tree_kind[lft]     = KIND_ABSENT;
                    tree_kind[lft + 1] = KIND_ABSENT;
                    tree_kind[par]     = KIND_FREE;
                    tree_age[par]      = '0;
                    best = par;
                end
            end
        end
        // free blocks age after every request, saturating
        for (int i = 0; i < NODE_COUNT; i++)
            if (tree_kind[i] == KIND_FREE && tree_age[i] != '1)
                tree_age[i]++;
        return res;
    endfunction

    // result checker
    always @(posedge clk)
    begin
        bba_out_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (exp_wr == exp_rd)
            begin
                $error("unexpected result transfer: %p", out_data);
                n_errors++;
            end
            else
            begin
                want = expect_mem[exp_rd % 1024];
                exp_rd++;
                if (out_data.status !== want.status)
                begin
                    $error("status: expected %0d, actual %0d", want.status, out_data.status);
                    n_errors++;
                end
                if (out_data.block_offset !== want.block_offset)
                begin
                    $error("block_offset: expected %0h, actual %0h",
                           want.block_offset, out_data.block_offset);
                    n_errors++;
                end
                if (out_data.block_order !== want.block_order)
                begin
                    $error("block_order: expected %0d, actual %0d",
                           want.block_order, out_data.block_order);
                    n_errors++;
                end
            end
        end
    end

    // receiver stalls: mostly short, sometimes long holds
    initial
    begin
        int hold;
        out_stall = 1'b0;
        forever
        begin
            @(negedge clk);
            if ($urandom_range(0, 99) < stall_pct)
            begin
                hold = ($urandom_range(0, 29) == 0) ? $urandom_range(20, 200)
                                                    : $urandom_range(1, 4);
                out_stall <= 1'b1;
                repeat (hold) @(negedge clk);
                out_stall <= 1'b0;
            end
        end
    end

    function automatic int pick_gap();
        if ($urandom_range(0, 99) >= gap_pct)
            return 0;
        if ($urandom_range(0, 19) == 0)
            return $urandom_range(20, 150);
        return $urandom_range(1, 4);
    endfunction

    // called at a falling edge; returns at a falling edge
    task automatic send_request(input logic kind, input logic [NAME_W-1:0] name,
                                input logic [SIZE_W-1:0] size);
        bba_in_t req;
        int      gap;
        req.req_type     = kind;
        req.block_name   = name;
        req.request_size = size;
        in_valid <= 1'b1;
        in_data  <= req;
        forever
        begin
            @(posedge clk);
            if (!in_stall)
                break;
        end
        expect_mem[exp_wr % 1024] = buddy_predict(req);
        exp_wr++;
        @(negedge clk);
        gap = pick_gap();
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            in_data  <= bba_in_t'({$urandom, $urandom});
            repeat (gap) @(negedge clk);
        end
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        while (exp_wr != exp_rd)
            @(negedge clk);
        repeat (10) @(negedge clk);
    endtask

    task automatic write_reg(input logic [CIDX_W-1:0] index, input logic [ORD_W-1:0] value);
        int unsigned v;
        drain();
        cfg_valid <= 1'b1;
        cfg_index <= index;
        cfg_data  <= value;
        forever
        begin
            @(posedge clk);
            if (cfg_ready)
                break;
        end
        v = (value > MAX_ORDER) ? MAX_ORDER : value;
        if (index == REG_TOP_ORDER)
        begin
            region_ord = v;
            clear_tree();
        end
        else if (index == REG_MIN_ORDER)
            floor_ord = v;
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    function automatic logic [SIZE_W-1:0] pick_size();
        int unsigned     k;
        longint unsigned lo;
        longint unsigned span;
        case ($urandom_range(0, 19))
            0: return '0;
            1: return SIZE_W'({$urandom, $urandom});
            2: return SIZE_W'(64'd1 << 40) + SIZE_W'($urandom);
            default:
            begin
                k  = region_ord - $urandom_range(0, (region_ord < 11) ? region_ord : 11);
                lo = (k == 0) ? 1 : (64'd1 << (k - 1)) + 1;
                span = (64'd1 << k) - lo + 1;
                return SIZE_W'(lo + ({$urandom, $urandom} % span));
            end
        endcase
    endfunction

    function automatic logic [NAME_W-1:0] pick_name();
        if ($urandom_range(0, 9) == 0)
            return NAME_W'($urandom);
        return name_pool[$urandom_range(0, 5)];
    endfunction

    task automatic test_directed();
        gap_pct   = 30;
        stall_pct = 20;
        send_request(REQ_ALLOC, 8'h00, 41'd1);
        send_request(REQ_ALLOC, 8'hFF, 41'd1024);
        send_request(REQ_ALLOC, 8'hFF, 41'd0);
        send_request(REQ_ALLOC, 8'hAA, {1'b1, 40'd0});
        send_request(REQ_ALLOC, 8'h55, 41'd300);
        send_request(REQ_FREE,  8'hC8, '1);
        send_request(REQ_FREE,  8'h00, 41'd0);
        send_request(REQ_FREE,  8'hFF, 41'd0);
        send_request(REQ_FREE,  8'h55, 41'd0);
        send_request(REQ_ALLOC, 8'h01, 41'd1024);
        send_request(REQ_FREE,  8'h01, 41'd0);
        write_reg(REG_TOP_ORDER, 6'd63);
        send_request(REQ_ALLOC, 8'h02, {1'b0, 40'hFF_FFFF_FFFF});
        send_request(REQ_ALLOC, 8'h03, 41'd1);
        send_request(REQ_FREE,  8'h02, 41'd0);
        send_request(REQ_ALLOC, 8'h03, 41'd1);
        send_request(REQ_ALLOC, 8'h03, {1'b0, 40'h80_0000_0000});
        send_request(REQ_FREE,  8'h03, 41'd0);
        write_reg(REG_TOP_ORDER, 6'd5);
        write_reg(REG_MIN_ORDER, 6'd63);
        send_request(REQ_ALLOC, 8'h04, 41'd1);
        write_reg(REG_MIN_ORDER, 6'd2);
        send_request(REQ_ALLOC, 8'h05, 41'd0);
        write_reg(8'd2, 6'd17);
        write_reg(8'hFF, 6'd0);
        send_request(REQ_ALLOC, 8'h05, 41'd1);
        write_reg(REG_TOP_ORDER, 6'd0);
        send_request(REQ_ALLOC, 8'h06, 41'd2);
        send_request(REQ_ALLOC, 8'h06, 41'd0);
        send_request(REQ_FREE,  8'h06, 41'd0);
    endtask

    task automatic test_random(input logic [ORD_W-1:0] top, input logic [ORD_W-1:0] bottom,
                               input int n_items);
        write_reg(REG_TOP_ORDER, top);
        write_reg(REG_MIN_ORDER, bottom);
        for (int i = 0; i < 6; i++)
            name_pool[i] = NAME_W'($urandom);
        for (int i = 0; i < n_items; i++)
        begin
            if (i % 100 == 50)
            begin
                gap_pct   = $urandom_range(0, 1) ? 0 : $urandom_range(10, 60);
                stall_pct = $urandom_range(0, 1) ? 0 : $urandom_range(10, 60);
            end
            if ($urandom_range(0, 99) < 60)
                send_request(REQ_ALLOC, pick_name(), pick_size());
            else
                send_request(REQ_FREE, pick_name(), SIZE_W'({$urandom, $urandom}));
        end
    endtask

    task automatic test_quiet_sender();
        for (int i = 0; i < 20; i++)
            send_request(REQ_ALLOC, pick_name(), pick_size());
        // hold off until the block has returned everything
        in_valid <= 1'b0;
        while (exp_wr != exp_rd)
            @(negedge clk);
        for (int i = 0; i < 20; i++)
            send_request(1'($urandom_range(0, 1)), pick_name(), pick_size());
    endtask

    initial
    begin
        n_errors   = 0;
        cycles     = 0;
        stall_pct  = 0;
        gap_pct    = 0;
        rst_n      = 1'b0;
        in_valid   = 1'b0;
        in_data    = '0;
        cfg_valid  = 1'b0;
        cfg_index  = '0;
        cfg_data   = '0;
        region_ord = RST_TOP_ORD;
        floor_ord  = RST_MIN_ORD;
        clear_tree();
        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        test_directed();
        test_random(6'd10, 6'd0, 300);
        test_random(6'd40, 6'd3, 200);
        test_quiet_sender();
        test_random(6'd6, 6'd1, 150);
        test_random(6'd20, 6'd18, 120);
        test_random(6'd3, 6'd0, 80);
        test_random(6'd12, 6'd40, 60);

        drain();
        repeat (100) @(posedge clk);
        if (n_errors == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

@@ files.f @@
rtl/bba_pkg.sv
rtl/bba_store.sv
rtl/bba_seq.sv
rtl/buddy_block_allocator.sv
rtl/bba_check.sv
tb/buddy_block_allocator_tb.sv
